>>> rtl/mpe_channel_allocator_macros.svh
// assertion macros for the channel allocator checker
// no dependencies; included by the checker file
`ifndef MPE_CHANNEL_ALLOCATOR_MACROS_SVH
`define MPE_CHANNEL_ALLOCATOR_MACROS_SVH

// property must hold at every clock edge out of reset
`define MPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent on one edge implies consequent on the next
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mpe_pkg.sv
// shared types and constants for the channel allocator
// no dependencies
package mpe_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_W         = $clog2(NUM_CHANNELS + 1);
	localparam int KEY_W        = 7;
	localparam int BEND_W       = 14;
	localparam int CMD_W        = 2;
	localparam int MASK_W       = 16;
	localparam int LAST_W       = 5;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_MEMBER_MASK = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LAST_MEMBER = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IGNORE_BEND = 2'd2;

	localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFE;
	localparam logic [LAST_W-1:0] LAST_RESET = 5'd16;

	localparam logic [CH_W-1:0] CH_NONE = '0;

	typedef enum logic [CMD_W-1:0] {
		CMD_NOTE_ON  = 2'd0,
		CMD_NOTE_OFF = 2'd1,
		CMD_ALL_OFF  = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	// search token that walks the cell chain
	typedef struct packed {
		logic              vld;
		cmd_t              cmd;
		logic [KEY_W-1:0]  key;
		logic [BEND_W-1:0] bend;
		logic [CH_W-1:0]   hit;
		logic [CH_W-1:0]   free;
	} tok_t;

	// broadcast write into one cell
	typedef struct packed {
		logic              en;
		logic [CH_W-1:0]   chan;
		logic [KEY_W-1:0]  key;
		logic [BEND_W-1:0] bend;
	} wr_t;

endpackage

>>> rtl/mpe_intf.sv
// handshake channel interfaces for the channel allocator
// depends on mpe_pkg
interface mpe_in_if import mpe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [KEY_W-1:0]  note_key;
	logic [BEND_W-1:0] bend_value;
	modport source (output valid, command, note_key, bend_value, input ready);
	modport sink   (input valid, command, note_key, bend_value, output ready);
endinterface

interface mpe_out_if import mpe_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] channel;
	logic [CH_W-1:0] notes_on;
	modport source (output valid, channel, notes_on, input ready);
	modport sink   (input valid, channel, notes_on, output ready);
endinterface

interface mpe_cfg_if import mpe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/mpe_channel_allocator.sv
// a result reaches the output register after its token has walked the whole cell chain
// one word at a time: a new word is taken only once the search token has walked
// the cell chain one channel per cycle and the result has moved to the output register
// a finished result waits in the output register while the next word is taken
// reset: asynchronous, all channels empty, config registers at their reset values
// top level: config registers, chain of cells and sequencer; depends on mpe_pkg
module mpe_channel_allocator import mpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mpe_in_if.sink    in_ch,
	mpe_out_if.source out_ch,
	mpe_cfg_if.sink   cfg_ch
);

	logic [MASK_W-1:0] mask_q;
	logic [LAST_W-1:0] last_q;
	logic              ign_q;

	tok_t tok [NUM_CHANNELS+1];
	wr_t  wr;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
			last_q <= LAST_RESET;
			ign_q  <= 1'b0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.addr)
				REG_MEMBER_MASK: mask_q <= cfg_ch.data[MASK_W-1:0];
				REG_LAST_MEMBER: last_q <= cfg_ch.data[LAST_W-1:0];
				REG_IGNORE_BEND: ign_q  <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	mpe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.tail   (tok[NUM_CHANNELS]),
		.launch (tok[0]),
		.wr     (wr)
	);

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
		mpe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.chan_num (CH_W'(i + 1)),
			.member   (mask_q[i]),
			.last     (last_q),
			.ign      (ign_q),
			.tok_i    (tok[i]),
			.wr       (wr),
			.tok_o    (tok[i+1])
		);
	end

endmodule

>>> rtl/mpe_cell.sv
// one table entry of the allocator chain: holds a note, updates the
// passing search token and registers it for the next cell; depends on mpe_pkg
module mpe_cell import mpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CH_W-1:0]   chan_num,
	input  logic              member,
	input  logic [LAST_W-1:0] last,
	input  logic              ign,
	input  tok_t              tok_i,
	input  wr_t               wr,
	output tok_t              tok_o
);

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [BEND_W-1:0] bend_q;
	tok_t              tok_q;

	logic act;
	logic key_eq;
	logic bend_eq;
	logic clr;
	logic wr_me;
	tok_t tok_nxt;

	assign act     = member && (LAST_W'(chan_num) <= last);
	assign key_eq  = valid_q && (key_q == tok_i.key);
	assign bend_eq = bend_q == tok_i.bend;
	assign wr_me   = wr.en && (wr.chan == chan_num);

	always_comb begin
		tok_nxt = tok_i;
		clr     = 1'b0;
		if (tok_i.vld) begin
			case (tok_i.cmd)
				CMD_NOTE_ON: begin
					if (act && tok_i.hit == CH_NONE) begin
						if (!valid_q) begin
							if (tok_i.free == CH_NONE) tok_nxt.free = chan_num;
						end else if (key_eq && bend_eq) begin
							tok_nxt.hit = chan_num;
						end
					end
				end
				CMD_NOTE_OFF: begin
					if (act && tok_i.hit == CH_NONE && key_eq && (ign || bend_eq)) begin
						tok_nxt.hit = chan_num;
						clr         = 1'b1;
					end
				end
				CMD_ALL_OFF: clr = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_me) begin
			valid_q <= 1'b1;
		end else if (clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me) begin
			key_q  <= wr.key;
			bend_q <= wr.bend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_o = tok_q;

endmodule

>>> rtl/mpe_ctrl.sv
// sequencer of the allocator: launches one token per word, resolves the
// token at the chain tail, keeps the note count and the output register
// depends on mpe_pkg and mpe_intf
module mpe_ctrl import mpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mpe_in_if.sink    in_ch,
	mpe_out_if.source out_ch,
	input  tok_t      tail,
	output tok_t      launch,
	output wr_t       wr
);

	state_t          state_q;
	state_t          state_nxt;
	tok_t            launch_q;
	logic [CH_W-1:0] pend_chan_q;
	logic [CH_W-1:0] notes_q;
	logic            out_vld_q;
	logic [CH_W-1:0] out_chan_q;
	logic [CH_W-1:0] out_notes_q;

	logic            accept;
	logic            tail_done;
	logic            load_out;
	logic [CH_W-1:0] res_chan;

	assign accept    = in_ch.valid && in_ch.ready;
	assign tail_done = (state_q == ST_SEARCH) && tail.vld;
	assign load_out  = (state_q == ST_DONE) && (!out_vld_q || out_ch.ready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_ch.valid) state_nxt = ST_SEARCH;
			ST_SEARCH: if (tail.vld) state_nxt = ST_DONE;
			ST_DONE:   if (!out_vld_q || out_ch.ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = state_q == ST_IDLE;
		case (tail.cmd)
			CMD_NOTE_ON:  res_chan = (tail.hit != CH_NONE) ? tail.hit : tail.free;
			CMD_NOTE_OFF: res_chan = tail.hit;
			default:      res_chan = CH_NONE;
		endcase
		// new note goes to the first free channel when nothing matched
		wr.en   = tail_done && (tail.cmd == CMD_NOTE_ON) && (tail.hit == CH_NONE)
			&& (tail.free != CH_NONE);
		wr.chan = tail.free;
		wr.key  = tail.key;
		wr.bend = tail.bend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= '0;
			notes_q  <= '0;
		end else begin
			state_q      <= state_nxt;
			launch_q.vld <= accept;
			if (accept) begin
				launch_q.cmd  <= cmd_t'(in_ch.command);
				launch_q.key  <= in_ch.note_key;
				launch_q.bend <= in_ch.bend_value;
				launch_q.hit  <= CH_NONE;
				launch_q.free <= CH_NONE;
			end
			if (tail_done) begin
				if (tail.cmd == CMD_ALL_OFF) begin
					notes_q <= '0;
				end else if (wr.en) begin
					notes_q <= notes_q + CH_W'(1);
				end else if (tail.cmd == CMD_NOTE_OFF && tail.hit != CH_NONE) begin
					notes_q <= notes_q - CH_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_done) pend_chan_q <= res_chan;
		if (load_out) begin
			out_chan_q  <= pend_chan_q;
			out_notes_q <= notes_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign launch          = launch_q;
	assign out_ch.valid    = out_vld_q;
	assign out_ch.channel  = out_chan_q;
	assign out_ch.notes_on = out_notes_q;

endmodule

>>> rtl/mpe_chk.sv
// port-level checker for the channel allocator, bound to the top level
// depends on mpe_pkg and mpe_channel_allocator_macros.svh
`include "mpe_channel_allocator_macros.svh"

module mpe_chk import mpe_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] out_channel,
	input logic [CH_W-1:0] out_notes_on
);

	// a waiting result word holds until taken
	`MPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(out_notes_on), "stalled result changed")
	// one word at a time: input closes right after an accept
	`MPE_ASSERT_NEXT(a_in_close, in_valid && in_ready, !in_ready, "input stayed open after accept")
	// channel number never beyond the table
	`MPE_ASSERT(a_chan_range, out_valid |-> (out_channel <= CH_W'(NUM_CHANNELS)), "channel out of range")
	// count never beyond the table
	`MPE_ASSERT(a_notes_range, out_valid |-> (out_notes_on <= CH_W'(NUM_CHANNELS)), "note count out of range")

endmodule

bind mpe_channel_allocator mpe_chk u_mpe_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_channel  (out_ch.channel),
	.out_notes_on (out_ch.notes_on)
);
